// ===== hdl/ram_pkg.sv =====
// ----------------------------------------------------------------------------
// ram_pkg: return address monitor shared definitions
// Opcode codes, result status codes and the structs passed between the
// table, the counter bank and the top level.
// ----------------------------------------------------------------------------
package ram_pkg;

  localparam int OPCODE_KINDS = 7;
  localparam int OPIDX_W      = 3;
  localparam int OP_W         = 8;
  localparam int ADDR_W       = 64;
  localparam int TOTAL_W      = 32;

  localparam logic [OP_W-1:0] OP_MSG    = 8'd0;
  localparam logic [OP_W-1:0] OP_CALL_A = 8'd1;
  localparam logic [OP_W-1:0] OP_CALL_B = 8'd2;
  localparam logic [OP_W-1:0] OP_RET_A  = 8'd3;
  localparam logic [OP_W-1:0] OP_RET_B  = 8'd4;
  localparam logic [OP_W-1:0] OP_CALL_C = 8'd5;
  localparam logic [OP_W-1:0] OP_CALL_D = 8'd6;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_UNEXPECTED = 3'd2,
    ST_UNKNOWN    = 3'd3,
    ST_FULL       = 3'd4
  } status_t;

  typedef struct packed {
    logic              call;
    logic              ret;
    logic [ADDR_W-1:0] addr;
  } tbl_req_t;

  typedef struct packed {
    logic empty;
    logic miss;
    logic full;
  } tbl_rsp_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] warning_total;
    logic [TOTAL_W-1:0] opcode_total;
  } cnt_rsp_t;

endpackage

// ===== hdl/ram_if.sv =====
// ----------------------------------------------------------------------------
// ram_if: return address monitor channels
// Request channel (opcode and address) and result channel, each with
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface ram_in_if;
  logic                        valid;
  logic                        ready;
  logic [ram_pkg::OP_W-1:0]    op_code;
  logic [ram_pkg::ADDR_W-1:0]  ret_address;

  modport source (output valid, output op_code, output ret_address, input ready);
  modport sink   (input valid, input op_code, input ret_address, output ready);
endinterface

interface ram_out_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [ram_pkg::TOTAL_W-1:0] warning_total;
  logic [ram_pkg::TOTAL_W-1:0] opcode_total;

  modport source (output valid, output status, output warning_total,
                  output opcode_total, input ready);
  modport sink   (input valid, input status, input warning_total,
                  input opcode_total, output ready);
endinterface

// ===== hdl/ram_table.sv =====
// ----------------------------------------------------------------------------
// ram_table: associative return address table
// Parallel compare of all live entries, lowest-free allocation on a new
// call, saturating count per entry, release when the count reaches zero.
// ----------------------------------------------------------------------------
module ram_table #(
  parameter int TABLE_ENTRIES = 16,
  parameter int COUNT_BITS    = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ram_pkg::tbl_req_t req,
  output ram_pkg::tbl_rsp_t rsp
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  logic [ram_pkg::ADDR_W-1:0] entry_addr_r [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0]      entry_cnt_r  [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0]      entry_cnt_nxt[TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] live;
  logic [TABLE_ENTRIES-1:0] hit;
  logic [TABLE_ENTRIES-1:0] free_oh;
  logic [TABLE_ENTRIES-1:0] alloc;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      live[i] = (entry_cnt_r[i] != '0);
      hit[i]  = live[i] && (entry_addr_r[i] == req.addr);
    end
  end

  assign free_oh = ~live & (live + TABLE_ENTRIES'(1));

  assign rsp.empty = ~|live;
  assign rsp.miss  = ~|hit;
  assign rsp.full  = rsp.miss && (&live);

  assign alloc = (req.call && rsp.miss) ? free_oh : '0;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      entry_cnt_nxt[i] = entry_cnt_r[i];
      if (req.call && hit[i] && entry_cnt_r[i] != CNT_MAX) begin
        entry_cnt_nxt[i] = entry_cnt_r[i] + CNT_ONE;
      end else if (alloc[i]) begin
        entry_cnt_nxt[i] = CNT_ONE;
      end else if (req.ret && hit[i]) begin
        entry_cnt_nxt[i] = entry_cnt_r[i] - CNT_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!rst_n) begin
        entry_cnt_r[i] <= '0;
      end else begin
        entry_cnt_r[i] <= entry_cnt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (alloc[i]) begin
        entry_addr_r[i] <= req.addr;
      end
    end
  end

  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit))
    else $error("address held by more than one live entry");

  a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
    (alloc != '0) |=> (entry_cnt_r[0] != '0) || $past(live[0]))
    else $error("allocation skipped the lowest free entry");

endmodule

// ===== hdl/ram_counters.sv =====
// ----------------------------------------------------------------------------
// ram_counters: opcode histogram and warning counter
// Saturating 32-bit counts; reports the updated values for the result.
// ----------------------------------------------------------------------------
module ram_counters (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic [ram_pkg::OP_W-1:0]     op,
  input  logic                         warn,
  output ram_pkg::cnt_rsp_t            rsp
);

  localparam logic [ram_pkg::TOTAL_W-1:0] TOT_MAX = {ram_pkg::TOTAL_W{1'b1}};
  localparam logic [ram_pkg::TOTAL_W-1:0] TOT_ONE = ram_pkg::TOTAL_W'(1);

  logic [ram_pkg::TOTAL_W-1:0] hist_r  [ram_pkg::OPCODE_KINDS];
  logic [ram_pkg::TOTAL_W-1:0] hist_nxt[ram_pkg::OPCODE_KINDS];
  logic [ram_pkg::TOTAL_W-1:0] warn_r;
  logic [ram_pkg::TOTAL_W-1:0] warn_nxt;
  logic [ram_pkg::TOTAL_W-1:0] op_total;
  logic [ram_pkg::OPIDX_W-1:0] sel;
  logic                        known;

  assign sel   = op[ram_pkg::OPIDX_W-1:0];
  assign known = (op < ram_pkg::OP_W'(ram_pkg::OPCODE_KINDS));

  always_comb begin
    op_total = '0;
    for (int i = 0; i < ram_pkg::OPCODE_KINDS; i++) begin
      hist_nxt[i] = hist_r[i];
      if (fire && known && sel == ram_pkg::OPIDX_W'(i) && hist_r[i] != TOT_MAX) begin
        hist_nxt[i] = hist_r[i] + TOT_ONE;
      end
      if (known && sel == ram_pkg::OPIDX_W'(i)) begin
        op_total = hist_nxt[i];
      end
    end
  end

  assign warn_nxt = (fire && warn && warn_r != TOT_MAX) ? warn_r + TOT_ONE : warn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warn_r <= '0;
      for (int i = 0; i < ram_pkg::OPCODE_KINDS; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      warn_r <= warn_nxt;
      for (int i = 0; i < ram_pkg::OPCODE_KINDS; i++) begin
        hist_r[i] <= hist_nxt[i];
      end
    end
  end

  assign rsp.warning_total = warn_nxt;
  assign rsp.opcode_total  = op_total;

  a_warn_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> warn_r >= $past(warn_r))
    else $error("warning counter decreased");

endmodule

// ===== hdl/return_address_monitor_top.sv =====
// ----------------------------------------------------------------------------
// return_address_monitor_top: return address monitor
// Request register, table and counter update, result register.
// ----------------------------------------------------------------------------
// Accepts one trace request per cycle while the result channel is not
// stalled, and returns one result per request via the request register,
// then the result register. The rate is set by the combinational parallel
// compare of the request address against every live table entry. No
// clearing pass after reset: entry counts and all totals clear with reset.
module return_address_monitor_top #(
  parameter int TABLE_ENTRIES = 16,
  parameter int COUNT_BITS    = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  ram_in_if.sink           in_ch,
  ram_out_if.source        out_ch
);

  logic                        s1_valid_r, s1_valid_nxt;
  logic [ram_pkg::OP_W-1:0]    s1_op_r;
  logic [ram_pkg::ADDR_W-1:0]  s1_addr_r;

  logic                        out_valid_r, out_valid_nxt;
  ram_pkg::status_t            out_status_r, out_status_nxt;
  logic [ram_pkg::TOTAL_W-1:0] out_warn_r;
  logic [ram_pkg::TOTAL_W-1:0] out_total_r;

  logic advance;
  logic work_fire;
  logic is_call, is_ret, is_known;
  logic warn;

  ram_pkg::tbl_req_t tbl_req;
  ram_pkg::tbl_rsp_t tbl_rsp;
  ram_pkg::cnt_rsp_t cnt_rsp;

  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign work_fire    = s1_valid_r && advance;

  assign s1_valid_nxt  = in_ch.ready ? in_ch.valid : s1_valid_r;
  assign out_valid_nxt = advance ? work_fire : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op_r   <= in_ch.op_code;
      s1_addr_r <= in_ch.ret_address;
    end
  end

  assign is_call  = s1_op_r inside {ram_pkg::OP_CALL_A, ram_pkg::OP_CALL_B,
                                    ram_pkg::OP_CALL_C, ram_pkg::OP_CALL_D};
  assign is_ret   = s1_op_r inside {ram_pkg::OP_RET_A, ram_pkg::OP_RET_B};
  assign is_known = is_call || is_ret || (s1_op_r == ram_pkg::OP_MSG);

  assign tbl_req.call = work_fire && is_call;
  assign tbl_req.ret  = work_fire && is_ret && !tbl_rsp.empty;
  assign tbl_req.addr = s1_addr_r;

  ram_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COUNT_BITS    (COUNT_BITS)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .rsp   (tbl_rsp)
  );

  assign warn = is_ret && (tbl_rsp.empty || tbl_rsp.miss);

  ram_counters u_counters (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (work_fire),
    .op    (s1_op_r),
    .warn  (warn),
    .rsp   (cnt_rsp)
  );

  always_comb begin
    if (!is_known) begin
      out_status_nxt = ram_pkg::ST_UNKNOWN;
    end else if (is_call && tbl_rsp.full) begin
      out_status_nxt = ram_pkg::ST_FULL;
    end else if (is_ret && tbl_rsp.empty) begin
      out_status_nxt = ram_pkg::ST_EMPTY;
    end else if (is_ret && tbl_rsp.miss) begin
      out_status_nxt = ram_pkg::ST_UNEXPECTED;
    end else begin
      out_status_nxt = ram_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (work_fire) begin
      out_status_r <= out_status_nxt;
      out_warn_r   <= cnt_rsp.warning_total;
      out_total_r  <= cnt_rsp.opcode_total;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.warning_total = out_warn_r;
  assign out_ch.opcode_total  = out_total_r;

  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ram_pkg::ST_UNKNOWN |-> out_total_r == '0)
    else $error("unknown opcode reported a nonzero histogram count");

  a_warn_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ram_pkg::ST_EMPTY ||
                    out_status_r == ram_pkg::ST_UNEXPECTED) |-> out_warn_r != '0)
    else $error("warning status with zero warning total");

  a_known_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ram_pkg::ST_UNKNOWN |-> out_total_r != '0)
    else $error("known opcode reported a zero histogram count");

endmodule
